@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the converter.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Checked at every rising clock edge, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/avcc2ab_pkg.sv @@
// Package for the AVCC to Annex B converter: status codes and constants.
// No dependencies; used by avcc_to_annexb_converter_top.
package avcc2ab_pkg;

    localparam int MAX_PREFIX_BYTES_DEF = 4;
    localparam logic [2:0] PREFIX_LEN_RESET = 3'd4;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_LAST = 8'h01;
    localparam logic [7:0] UNIT_TYPE_MASK  = 8'h1F;

    // Positions of the last start code byte and the header byte inside the five-transaction start code group.
    localparam logic [2:0] GRP_IDX_CODE_LAST = 3'd3;
    localparam logic [2:0] GRP_IDX_HEADER    = 3'd4;

endpackage

@@ rtl/core/avcc_to_annexb_converter_top.sv @@
// AVCC to Annex B converter: one byte transaction in, zero, one or five transactions out.
// Depends on avcc2ab_pkg and assert_macros.svh.
//
// The block takes one sample byte per cycle unless the output group stalls it, and updates
// the prefix, NAL and sample counters in the same cycle; its results go into an output group
// register that frees its slot in the cycle the last result is taken. The first byte of
// each NAL produces five results (the start code 00 00 00 01 and the header byte), which
// the output register delivers one at a time while the input is stalled. Bytes outside a
// sample and bytes skipped after a malformed length give no result. The prefix size is
// written through i_cfg_we/i_cfg_data; 0 acts as 1 and values above MAX_PREFIX_BYTES act
// as MAX_PREFIX_BYTES.
`include "assert_macros.svh"

module avcc_to_annexb_converter_top #(
    parameter int MAX_PREFIX_BYTES = avcc2ab_pkg::MAX_PREFIX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_sample_start,
    input  logic [31:0] i_sample_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [4:0]  o_unit_type,
    output logic        o_code_start,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import avcc2ab_pkg::*;

    localparam int AW = 8 * MAX_PREFIX_BYTES;
    localparam logic [2:0] MAX_LS = 3'(MAX_PREFIX_BYTES);

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_HEADER,
        PH_BODY,
        PH_SKIP
    } t_phase;

    logic [2:0]    r_prefix_len;
    t_phase        r_phase, n_phase;
    logic [2:0]    r_prefix_count, n_prefix_count;
    logic [AW-1:0] r_length_accum, n_length_accum;
    logic [31:0]   r_nal_remaining, n_nal_remaining;
    logic [31:0]   r_sample_remaining, n_sample_remaining;
    logic [4:0]    r_type, n_type;

    // Output group: either one result, or a start code group of five.
    logic          r_grp_valid, n_grp_valid;
    logic          r_grp_hdr, n_grp_hdr;
    logic [7:0]    r_grp_byte, n_grp_byte;
    t_status       r_grp_status, n_grp_status;
    logic [2:0]    r_grp_idx;

    logic [2:0]    eff_size;
    logic          in_accept;
    logic          out_accept;

    always_comb begin
        eff_size = r_prefix_len;
        if (eff_size == 3'd0) begin
            eff_size = 3'd1;
        end
        if (eff_size > MAX_LS) begin
            eff_size = MAX_LS;
        end
    end

    assign o_out_valid  = r_grp_valid;
    assign o_last       = !r_grp_hdr || (r_grp_idx == GRP_IDX_HEADER);
    assign o_code_start = r_grp_hdr && (r_grp_idx == 3'd0);
    assign o_unit_type  = r_type;
    assign o_status     = r_grp_status;
    assign out_accept   = r_grp_valid && i_out_ready;
    assign o_in_ready   = !r_grp_valid || (i_out_ready && o_last);
    assign in_accept    = i_in_valid && o_in_ready;

    always_comb begin
        if (!r_grp_hdr || r_grp_idx == GRP_IDX_HEADER) begin
            o_out_byte = r_grp_byte;
        end else if (r_grp_idx == GRP_IDX_CODE_LAST) begin
            o_out_byte = START_CODE_LAST;
        end else begin
            o_out_byte = START_CODE_ZERO;
        end
    end

    always_comb begin
        n_phase            = r_phase;
        n_prefix_count     = r_prefix_count;
        n_length_accum     = r_length_accum;
        n_nal_remaining    = r_nal_remaining;
        n_sample_remaining = r_sample_remaining;
        n_type             = r_type;
        n_grp_valid        = 1'b0;
        n_grp_hdr          = 1'b0;
        n_grp_byte         = i_data_byte;
        n_grp_status       = ST_DATA;

        if (i_sample_start) begin
            n_sample_remaining = i_sample_bytes;
            n_phase            = PH_PREFIX;
            n_prefix_count     = 3'd0;
            n_length_accum     = '0;
            n_nal_remaining    = 32'd0;
        end

        if (n_sample_remaining != 32'd0) begin
            n_sample_remaining = n_sample_remaining - 32'd1;
            case (n_phase)
                PH_PREFIX: begin
                    n_length_accum = AW'({n_length_accum, i_data_byte});
                    n_prefix_count = n_prefix_count + 3'd1;
                    if (n_prefix_count >= eff_size) begin
                        n_prefix_count = 3'd0;
                        if (n_length_accum == '0 ||
                            32'(n_length_accum) > n_sample_remaining) begin
                            n_grp_valid  = 1'b1;
                            n_grp_byte   = 8'd0;
                            n_grp_status = ST_MALFORMED;
                            n_phase      = PH_SKIP;
                        end else begin
                            n_nal_remaining = 32'(n_length_accum);
                            n_phase         = PH_HEADER;
                        end
                        n_length_accum = '0;
                    end else if (n_sample_remaining == 32'd0) begin
                        n_grp_valid    = 1'b1;
                        n_grp_byte     = 8'd0;
                        n_grp_status   = ST_TRUNCATED;
                        n_prefix_count = 3'd0;
                        n_length_accum = '0;
                        n_phase        = PH_SKIP;
                    end
                end
                PH_HEADER: begin
                    n_type          = 5'(i_data_byte & UNIT_TYPE_MASK);
                    n_grp_valid     = 1'b1;
                    n_grp_hdr       = 1'b1;
                    n_nal_remaining = n_nal_remaining - 32'd1;
                    n_phase = (n_nal_remaining != 32'd0) ? PH_BODY : PH_PREFIX;
                end
                PH_BODY: begin
                    n_grp_valid = 1'b1;
                    if (n_nal_remaining != 32'd0) begin
                        n_nal_remaining = n_nal_remaining - 32'd1;
                    end
                    if (n_nal_remaining == 32'd0) begin
                        n_phase = PH_PREFIX;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_len       <= PREFIX_LEN_RESET;
            r_phase            <= PH_PREFIX;
            r_prefix_count     <= 3'd0;
            r_length_accum     <= '0;
            r_nal_remaining    <= 32'd0;
            r_sample_remaining <= 32'd0;
            r_type             <= 5'd0;
            r_grp_valid        <= 1'b0;
            r_grp_hdr          <= 1'b0;
            r_grp_idx          <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_prefix_len <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase            <= n_phase;
                r_prefix_count     <= n_prefix_count;
                r_length_accum     <= n_length_accum;
                r_nal_remaining    <= n_nal_remaining;
                r_sample_remaining <= n_sample_remaining;
                r_type             <= n_type;
                r_grp_valid        <= n_grp_valid;
                r_grp_hdr          <= n_grp_hdr;
                r_grp_idx          <= 3'd0;
            end else if (out_accept) begin
                if (o_last) begin
                    r_grp_valid <= 1'b0;
                end else begin
                    r_grp_idx <= r_grp_idx + 3'd1;
                end
            end
        end
    end

    // Payload of the output group; no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_grp_byte   <= n_grp_byte;
            r_grp_status <= n_grp_status;
        end
    end

    `ASSERT_CLK(a_grp_idx_range, i_clk, i_rst_n, r_grp_idx <= GRP_IDX_HEADER, "group index out of range")
    `ASSERT_CLK(a_status_single, i_clk, i_rst_n, (r_grp_valid && r_grp_status != ST_DATA) |-> !r_grp_hdr, "status result inside a start code group")
    `ASSERT_CLK(a_group_holds, i_clk, i_rst_n, (out_accept && !o_last) |=> o_out_valid, "start code group cut short")
    `ASSERT_CLK(a_code_start_zero, i_clk, i_rst_n, (o_out_valid && o_code_start) |-> (o_out_byte == START_CODE_ZERO && o_status == ST_DATA), "bad first start code byte")

endmodule

@@ verif/avcc_to_annexb_converter_top_tb.sv @@
// Self-checking testbench for avcc_to_annexb_converter_top.
// Depends on avcc2ab_pkg and the converter RTL; runs directed samples, then random samples
// under several length prefix sizes, checking every output transaction against a predictor.
`timescale 1ns / 1ps

module avcc_to_annexb_converter_top_tb;
    import avcc2ab_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [31:0] size;
    } avcc_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [4:0] unit_type;
        logic       code_start;
        t_status    status;
        logic       last;
    } annexb_result_t;

    typedef enum logic [1:0] {
        AWAIT_PREFIX,
        AWAIT_HEADER,
        IN_BODY,
        SKIP_REST
    } conv_phase_t;

    typedef enum int {
        FL_NONE,
        FL_ZERO_LEN,
        FL_OVERRUN,
        FL_TRUNCATED,
        FL_PREFIX_AT_END,
        FL_EARLY_START,
        FL_TRAILING
    } sample_flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_data = 3'd0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_data = 8'd0;
    logic        in_start = 1'b0;
    logic [31:0] in_size = 32'd0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic [4:0]  o_unit_type;
    logic        o_code_start;
    logic [1:0]  o_status;
    logic        o_last;

    avcc_item_t     avcc_pending[$];
    annexb_result_t annexb_due[$];
    avcc_item_t     cur_item;
    int             fails = 0;
    int unsigned    items_queued = 0;
    logic           calm = 1'b0;

    // Predictor copy of the converter state and its prefix size register.
    logic [2:0]  len_size_cfg = PREFIX_LEN_RESET;
    conv_phase_t conv_ph = AWAIT_PREFIX;
    logic [2:0]  pfx_cnt = 3'd0;
    logic [31:0] len_acc = 32'd0;
    logic [31:0] nal_left = 32'd0;
    logic [31:0] smp_left = 32'd0;
    logic [4:0]  nal_t = 5'd0;

    avcc_to_annexb_converter_top DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (in_data),
        .i_sample_start (in_start),
        .i_sample_bytes (in_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_out_byte     (o_out_byte),
        .o_unit_type    (o_unit_type),
        .o_code_start   (o_code_start),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned eff_prefix_len(input logic [2:0] v);
        if (v == 3'd0) begin
            return 1;
        end
        if (v > MAX_PREFIX_BYTES_DEF) begin
            return MAX_PREFIX_BYTES_DEF;
        end
        return 32'(v);
    endfunction

    function automatic void emit(input logic [7:0] b, input logic cs, input t_status st,
                                 input logic lst);
        annexb_result_t r;
        r.out_byte   = b;
        r.unit_type  = nal_t;
        r.code_start = cs;
        r.status     = st;
        r.last       = lst;
        annexb_due.push_back(r);
    endfunction

    task automatic predict_annexb(input avcc_item_t it);
        int unsigned need;
        need = eff_prefix_len(len_size_cfg);
        if (it.start) begin
            smp_left = it.size;
            conv_ph  = AWAIT_PREFIX;
            pfx_cnt  = 3'd0;
            len_acc  = 32'd0;
            nal_left = 32'd0;
        end
        // Bytes outside a sample produce nothing.
        if (smp_left != 32'd0) begin
            smp_left = smp_left - 32'd1;
            case (conv_ph)
                AWAIT_PREFIX: begin
                    len_acc = {len_acc[23:0], it.data};
                    pfx_cnt = pfx_cnt + 3'd1;
                    if (pfx_cnt >= need) begin
                        pfx_cnt = 3'd0;
                        if (len_acc == 32'd0 || len_acc > smp_left) begin
                            emit(8'h00, 1'b0, ST_MALFORMED, 1'b1);
                            conv_ph = SKIP_REST;
                        end else begin
                            nal_left = len_acc;
                            conv_ph  = AWAIT_HEADER;
                        end
                        len_acc = 32'd0;
                    end else if (smp_left == 32'd0) begin
                        emit(8'h00, 1'b0, ST_TRUNCATED, 1'b1);
                        pfx_cnt = 3'd0;
                        len_acc = 32'd0;
                        conv_ph = SKIP_REST;
                    end
                end
                AWAIT_HEADER: begin
                    nal_t = it.data[4:0];
                    emit(START_CODE_ZERO, 1'b1, ST_DATA, 1'b0);
                    emit(START_CODE_ZERO, 1'b0, ST_DATA, 1'b0);
                    emit(START_CODE_ZERO, 1'b0, ST_DATA, 1'b0);
                    emit(START_CODE_LAST, 1'b0, ST_DATA, 1'b0);
                    emit(it.data, 1'b0, ST_DATA, 1'b1);
                    nal_left = nal_left - 32'd1;
                    conv_ph  = (nal_left != 32'd0) ? IN_BODY : AWAIT_PREFIX;
                end
                IN_BODY: begin
                    emit(it.data, 1'b0, ST_DATA, 1'b1);
                    if (nal_left != 32'd0) begin
                        nal_left = nal_left - 32'd1;
                    end
                    if (nal_left == 32'd0) begin
                        conv_ph = AWAIT_PREFIX;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // Driver: presents pending bytes and predicts each accepted transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_annexb(cur_item);
            end
            if (!in_valid || o_in_ready) begin
                if (avcc_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
                    cur_item = avcc_pending.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= cur_item.data;
                    in_start <= cur_item.start;
                    in_size  <= cur_item.size;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted output transaction with the oldest expectation.
    always @(posedge clk) begin
        annexb_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (annexb_due.size() == 0) begin
                    $error("unexpected output transaction: out_byte 0x%0h status %0d",
                           o_out_byte, o_status);
                    fails++;
                end else begin
                    want = annexb_due.pop_front();
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("unit_type", want.unit_type, o_unit_type);
                    check_field("code_start", want.code_start, o_code_start);
                    check_field("status", want.status, o_status);
                    check_field("last", want.last, o_last);
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic push_item(input logic [7:0] d, input logic st, input logic [31:0] sz);
        avcc_item_t it;
        it.data  = d;
        it.start = st;
        it.size  = sz;
        avcc_pending.push_back(it);
    endtask

    // Builds one AVCC sample for the current prefix size, optionally with a defect.
    task automatic queue_sample(input sample_flaw_t flaw);
        logic [7:0]  img[$];
        logic [31:0] nal_len;
        logic [31:0] declared;
        int unsigned need, nals, len, k, n, send;
        int j;
        need = eff_prefix_len(len_size_cfg);
        nals = $urandom_range(1, 3);
        for (k = 0; k < nals; k++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            nal_len = len;
            if (k == nals - 1 && flaw == FL_ZERO_LEN) begin
                nal_len = 32'd0;
            end else if (k == nals - 1 && flaw == FL_OVERRUN) begin
                if (need == 4 && $urandom_range(0, 1) == 1) begin
                    nal_len = $urandom() | 32'h0100_0000;
                end else begin
                    nal_len = len + $urandom_range(1, 3);
                end
            end
            for (j = need - 1; j >= 0; j--) begin
                img.push_back(nal_len[8*j +: 8]);
            end
            for (n = 0; n < len; n++) begin
                img.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (flaw == FL_TRUNCATED && need > 1) begin
            n = $urandom_range(1, need - 1);
            repeat (n) img.push_back(8'($urandom_range(0, 255)));
        end else if (flaw == FL_PREFIX_AT_END) begin
            nal_len = $urandom_range(1, 200);
            for (j = need - 1; j >= 0; j--) begin
                img.push_back(nal_len[8*j +: 8]);
            end
        end
        declared = 32'(img.size());
        send = img.size();
        // An early start leaves the sample short; the next sample start aborts it.
        if (flaw == FL_EARLY_START) begin
            if ($urandom_range(0, 1) == 1) begin
                declared = $urandom() | 32'h8000_0000;
            end else begin
                declared = declared + $urandom_range(1, 20);
            end
            send = $urandom_range(1, img.size());
        end
        for (k = 0; k < send; k++) begin
            push_item(img[k], k == 0, (k == 0) ? declared : $urandom());
        end
        items_queued += send;
        if (flaw == FL_TRAILING) begin
            repeat ($urandom_range(1, 4)) push_item(8'($urandom_range(0, 255)), 1'b0, $urandom());
        end
    endtask

    task automatic queue_random_phase(input int unsigned target);
        int unsigned base, r;
        sample_flaw_t flaw;
        base = items_queued;
        while (items_queued - base < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                flaw = FL_NONE;
            end else if (r < 53) begin
                flaw = FL_ZERO_LEN;
            end else if (r < 61) begin
                flaw = FL_OVERRUN;
            end else if (r < 69) begin
                flaw = FL_TRUNCATED;
            end else if (r < 75) begin
                flaw = FL_PREFIX_AT_END;
            end else if (r < 85) begin
                flaw = FL_EARLY_START;
            end else begin
                flaw = FL_TRAILING;
            end
            queue_sample(flaw);
            // Occasional stray byte, sometimes opening a tiny broken sample.
            if ($urandom_range(0, 9) == 0) begin
                push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 5));
            end
        end
    endtask

    task automatic wait_drained();
        // Sampled away from the rising edge so the driver's updates have settled.
        @(negedge clk);
        while (avcc_pending.size() != 0 || in_valid || annexb_due.size() != 0) begin
            @(negedge clk);
        end
        // Skipped bytes give no result, so allow the block to settle.
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length_size(input logic [2:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        len_size_cfg = v;
    endtask

    initial begin
        logic [2:0] cfg_plan[6];
        int i;
        cfg_plan = '{3'd1, 3'd0, 3'd2, 3'd7, 3'd5, 3'd4};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes outside a sample, and a sample of size zero, are ignored.
        push_item(8'hFF, 1'b0, 32'd0);
        push_item(8'hAA, 1'b1, 32'd0);
        // Two-byte NAL with type 31, then a zero length; the tail byte is skipped.
        push_item(8'h00, 1'b1, 32'd11);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h02, 1'b0, 32'd0);
        push_item(8'hFF, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'hAB, 1'b0, 32'd0);
        // NAL longer than the rest of the sample.
        push_item(8'h00, 1'b1, 32'd5);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h05, 1'b0, 32'd0);
        push_item(8'h11, 1'b0, 32'd0);
        // Huge sample cut short by the next sample start, which ends in a partial prefix.
        push_item(8'hEE, 1'b1, 32'hFFFF_FFFF);
        push_item(8'h00, 1'b1, 32'd2);
        push_item(8'h01, 1'b0, 32'd0);
        // Full prefix as the last byte of the sample.
        push_item(8'h00, 1'b1, 32'd4);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h07, 1'b0, 32'd0);
        wait_drained();

        // Prefix size shrinks while a prefix is half gathered.
        push_item(8'h00, 1'b1, 32'd6);
        push_item(8'h00, 1'b0, 32'd0);
        wait_drained();
        write_length_size(3'd3);
        push_item(8'h01, 1'b0, 32'd0);
        push_item(8'h60, 1'b0, 32'd0);
        push_item(8'h00, 1'b0, 32'd0);
        push_item(8'h7E, 1'b0, 32'd0);
        wait_drained();

        for (i = 0; i < 6; i++) begin
            write_length_size(cfg_plan[i]);
            calm = (cfg_plan[i] == 3'd7);
            queue_random_phase(8);
            wait_drained();
            calm = 1'b0;
        end

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/avcc2ab_pkg.sv
rtl/core/avcc_to_annexb_converter_top.sv
verif/avcc_to_annexb_converter_top_tb.sv
